### design/next_present_position_finder_defines.svh
// assertion macros for the next present position finder
// used by the rtl files of this block, no other dependencies
`ifndef NEXT_PRESENT_POSITION_FINDER_DEFINES_SVH
`define NEXT_PRESENT_POSITION_FINDER_DEFINES_SVH
`ifndef ASSERT_OFF
`define NPPF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define NPPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NPPF_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define NPPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### design/nppf_pkg.sv
// shared constants and types for the next present position finder
// no dependencies
package nppf_pkg;

  localparam int POS_W             = 11;
  localparam int COUNT_W           = 11;
  localparam int MAX_POSITIONS_DEF = 1024;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

  typedef enum logic [0:0] {
    ACT_REMOVE = 1'b0,
    ACT_QUERY  = 1'b1
  } action_t;

endpackage

### design/next_present_position_finder.sv
// next present position finder: successor table with path compression
// depends on nppf_pkg and next_present_position_finder_defines.svh
//
// usage:
//   input channel (in_valid / in_stall) carries action and position.
//   a remove points the entry of position at position+1 (or at 0 for the
//   last position) and gives no result. a query gives one result on the
//   output channel (out_valid / out_stall): found and nearest, the nearest
//   present position at or right of position.
//   cfg_valid / cfg_ready writes position_count; cfg_ready is always high.
// operation:
//   a remove is a single table write and leaves the block idle. a query walks the
//   pointer chain through the single-port-read table, one entry per cycle,
//   to find the root, then writes the root into each entry of the chain,
//   then loads the result register. an invalid query loads it directly.
//   in_stall is high whenever a query is in flight.
// reset:
//   after rst the table is cleared to identity, one entry per cycle, for
//   all MAX_POSITIONS + 1 entries, with in_stall high.
// stall:
//   a finished result waits in the output register while out_stall is high;
//   a query that finishes behind it holds in_stall high until it transfers.
`include "next_present_position_finder_defines.svh"

module next_present_position_finder #(
  parameter int MAX_POSITIONS = nppf_pkg::MAX_POSITIONS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        action,
  input  logic [nppf_pkg::POS_W-1:0]  position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic [nppf_pkg::POS_W-1:0]  nearest,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [nppf_pkg::COUNT_W-1:0] cfg_data
);
  import nppf_pkg::*;

  localparam int DEPTH = MAX_POSITIONS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (AW > COUNT_W) ? AW : COUNT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND,
    S_COMP,
    S_RESULT
  } state_t;

  state_t               state;
  logic [AW-1:0]        clr_idx;
  logic [COUNT_W-1:0]   count;
  logic [AW-1:0]        cur;
  logic [AW-1:0]        root;
  logic [AW-1:0]        qpos;
  logic                 res_found;
  logic [POS_W-1:0]     res_nearest;

  logic [AW-1:0]        mem [DEPTH];
  logic [AW-1:0]        mem_rdata;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;

  logic [CW-1:0]        eff_count;
  logic [AW-1:0]        pos_idx;
  logic                 pos_ok;
  logic                 pos_last;
  logic                 in_xfer;
  logic                 out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign eff_count = (CW'(count) > CW'(MAX_POSITIONS)) ? CW'(MAX_POSITIONS) : CW'(count);
  assign pos_idx   = AW'(position);
  assign pos_ok    = (position != '0) && (CW'(position) <= eff_count);
  assign pos_last  = (CW'(position) == eff_count);

  // table storage, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = clr_idx;
      end
      S_IDLE: begin
        if (in_xfer && pos_ok) begin
          if (action == ACT_QUERY) begin
            mem_re    = 1'b1;
            mem_raddr = pos_idx;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = pos_idx;
            mem_wdata = pos_last ? '0 : AW'(pos_idx + 1'b1);
          end
        end
      end
      S_FIND: begin
        if (mem_rdata != cur) begin
          mem_re    = 1'b1;
          mem_raddr = mem_rdata;
        end else if (cur != qpos) begin
          mem_re    = 1'b1;
          mem_raddr = qpos;
        end
      end
      S_COMP: begin
        mem_we    = 1'b1;
        mem_waddr = cur;
        mem_wdata = root;
        if (mem_rdata != root) begin
          mem_re    = 1'b1;
          mem_raddr = mem_rdata;
        end
      end
      S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      count     <= COUNT_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        count <= cfg_data;
      end
      if (out_valid && !out_stall && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= AW'(clr_idx + 1'b1);
          if (clr_idx == AW'(MAX_POSITIONS)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer && action == ACT_QUERY) begin
            qpos <= pos_idx;
            cur  <= pos_idx;
            if (pos_ok) begin
              state <= S_FIND;
            end else begin
              res_found   <= 1'b0;
              res_nearest <= '0;
              state       <= S_RESULT;
            end
          end
        end
        S_FIND: begin
          if (mem_rdata != cur) begin
            cur <= mem_rdata;
          end else begin
            root        <= cur;
            res_found   <= (cur != '0) && (CW'(cur) <= eff_count);
            res_nearest <= ((cur != '0) && (CW'(cur) <= eff_count)) ? POS_W'(cur) : '0;
            if (cur != qpos) begin
              cur   <= qpos;
              state <= S_COMP;
            end else begin
              state <= S_RESULT;
            end
          end
        end
        S_COMP: begin
          if (mem_rdata != root) begin
            cur <= mem_rdata;
          end else begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            found     <= res_found;
            nearest   <= res_nearest;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `NPPF_ASSERT_IMPL(a_comp_not_root, clk, rst, state == S_COMP, cur != root, "compression rewrites the root")
  `NPPF_ASSERT_IMPL(a_walk_upward, clk, rst, state == S_FIND && mem_rdata != cur, mem_rdata > cur || mem_rdata == '0, "pointer walk moved downward")
  `NPPF_ASSERT_IMPL(a_result_right, clk, rst, state == S_RESULT && res_found, CW'(root) >= CW'(qpos), "result lies left of query")
  `NPPF_ASSERT_IMPL(a_notfound_zero, clk, rst, out_valid && !found, nearest == '0, "not-found result with nonzero position")
  `NPPF_ASSERT_NEXT(a_result_loads, clk, rst, state == S_RESULT && out_free, out_valid && state == S_IDLE, "result not loaded")

endmodule
